/* src/ppi_pkg.sv */
// Package with the request, result and state types of the parallel peripheral interface.
package ppi_pkg;

    typedef enum logic [1:0] {
        OP_CPU_READ  = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_STROBE    = 2'd2,
        OP_ACK       = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        PORT_A   = 2'd0,
        PORT_B   = 2'd1,
        PORT_C   = 2'd2,
        PORT_CTL = 2'd3
    } port_e;

    localparam logic [1:0] GA_MODE_0 = 2'd0;
    localparam logic [1:0] GA_MODE_1 = 2'd1;
    localparam logic [1:0] GA_MODE_2 = 2'd2;

    localparam logic [2:0] FLAG_INT  = 3'd0;
    localparam logic [2:0] FLAG_WINT = 3'd1;
    localparam logic [2:0] FLAG_RINT = 3'd2;
    localparam logic [2:0] FLAG_IBF  = 3'd3;
    localparam logic [2:0] FLAG_STB  = 3'd4;
    localparam logic [2:0] FLAG_DAK  = 3'd5;
    localparam logic [2:0] FLAG_OBF  = 3'd6;

    localparam logic EN_RIE = 1'b0;
    localparam logic EN_WIE = 1'b1;

    localparam logic [1:0] DIR_CLO = 2'd0;
    localparam logic [1:0] DIR_B   = 2'd1;
    localparam logic [1:0] DIR_CHI = 2'd2;
    localparam logic [1:0] DIR_A   = 2'd3;

    localparam logic [2:0] CBIT_INTR = 3'd3;
    localparam logic [2:0] CBIT_RIE  = 3'd4;
    localparam logic [2:0] CBIT_IBF  = 3'd5;
    localparam logic [2:0] CBIT_WIE  = 3'd6;
    localparam logic [2:0] CBIT_OBF  = 3'd7;

    localparam logic [6:0] FLAGS_RESET   = 7'b111_0000;
    localparam logic [3:0] DIR_RESET     = 4'hF;
    localparam logic [7:0] C_MODE2_RESET = 8'h80;

    typedef struct packed {
        op_e        op;
        port_e      port;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_value;
        logic [7:0] port_b_value;
        logic [7:0] port_c_value;
        logic       a_driven;
        logic       b_driven;
        logic       c_low_driven;
        logic       c_high_driven;
        logic       bit_command_seen;
        logic       input_full;
        logic       output_full;
    } res_t;

    typedef struct packed {
        logic [7:0] latch_a;
        logic [7:0] latch_b;
        logic [7:0] latch_c;
        logic [7:0] strobe_buffer;
        logic [1:0] ga_mode;
        logic       gb_mode;
        logic [3:0] dir;
        logic [6:0] flags;
        logic [1:0] ien;
    } state_t;

endpackage

/* src/parallel_peripheral_interface.sv */
// Top level of the parallel peripheral interface: request register, state and result register.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid / s_ready  s_req (ppi_pkg::req_t)
//   m_       out        m_valid / m_ready  m_res (ppi_pkg::res_t)
//
// One request per cycle is taken while the result channel is not stalled.
// The request register feeds a single combinational update that loads the result register.
// Reset clears the ports, puts all ports in input mode and sets STB, DAK and OBF.
// A stalled result holds the result register; one further request waits in the request register.
module parallel_peripheral_interface (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ppi_pkg::req_t   s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output ppi_pkg::res_t   m_res
);

    logic            req_valid_reg;
    ppi_pkg::req_t   req_reg;
    logic            res_valid_reg;
    ppi_pkg::res_t   res_reg;
    ppi_pkg::state_t state_reg;
    ppi_pkg::state_t state_next;
    ppi_pkg::res_t   res_next;
    logic            fire;

    assign fire    = req_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || fire;
    assign m_valid = res_valid_reg;
    assign m_res   = res_reg;

    ppi_step u_step (
        .state_in  (state_reg),
        .req       (req_reg),
        .state_out (state_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_ready) begin
            req_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (fire) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.latch_a       <= '0;
            state_reg.latch_b       <= '0;
            state_reg.latch_c       <= '0;
            state_reg.strobe_buffer <= '0;
            state_reg.ga_mode       <= ppi_pkg::GA_MODE_0;
            state_reg.gb_mode       <= 1'b0;
            state_reg.dir           <= ppi_pkg::DIR_RESET;
            state_reg.flags         <= ppi_pkg::FLAGS_RESET;
            state_reg.ien           <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/ppi_step.sv */
// Combinational update of the interface state and result for one request.
module ppi_step (
    input  ppi_pkg::state_t state_in,
    input  ppi_pkg::req_t   req,
    output ppi_pkg::state_t state_out,
    output ppi_pkg::res_t   res
);

    always_comb begin
        ppi_pkg::state_t s;
        logic            m2;
        logic            wint;
        logic            rint;
        logic            to_c;
        logic [7:0]      v;
        logic [2:0]      bit_idx;

        s       = state_in;
        m2      = (s.ga_mode == ppi_pkg::GA_MODE_2);
        wint    = 1'b0;
        rint    = 1'b0;
        to_c    = 1'b1;
        v       = req.data;
        bit_idx = req.data[3:1];
        res     = '0;

        case (req.op)
            ppi_pkg::OP_CPU_READ: begin
                case (req.port)
                    ppi_pkg::PORT_A: begin
                        if (m2) begin
                            s.flags[ppi_pkg::FLAG_RINT] = 1'b0;
                            if (s.flags[ppi_pkg::FLAG_IBF]) begin
                                s.latch_a = s.strobe_buffer;
                            end
                            if (s.flags[ppi_pkg::FLAG_STB]) begin
                                s.flags[ppi_pkg::FLAG_IBF] = 1'b0;
                            end
                        end
                        res.read_data = s.latch_a;
                    end
                    ppi_pkg::PORT_B: begin
                        res.read_data = s.latch_b;
                    end
                    ppi_pkg::PORT_C: begin
                        if (m2) begin
                            wint = s.flags[ppi_pkg::FLAG_OBF] & s.ien[ppi_pkg::EN_WIE]
                                 & s.flags[ppi_pkg::FLAG_DAK];
                            rint = s.flags[ppi_pkg::FLAG_IBF] & s.ien[ppi_pkg::EN_RIE]
                                 & s.flags[ppi_pkg::FLAG_STB];
                            s.flags[ppi_pkg::FLAG_WINT] = wint;
                            s.flags[ppi_pkg::FLAG_RINT] = rint;
                            s.flags[ppi_pkg::FLAG_INT]  = wint | rint;
                            s.latch_c[ppi_pkg::CBIT_OBF]  = s.flags[ppi_pkg::FLAG_OBF];
                            s.latch_c[ppi_pkg::CBIT_WIE]  = s.ien[ppi_pkg::EN_WIE];
                            s.latch_c[ppi_pkg::CBIT_IBF]  = s.flags[ppi_pkg::FLAG_IBF];
                            s.latch_c[ppi_pkg::CBIT_RIE]  = s.ien[ppi_pkg::EN_RIE];
                            s.latch_c[ppi_pkg::CBIT_INTR] = s.flags[ppi_pkg::FLAG_INT];
                        end
                        res.read_data = s.latch_c;
                    end
                    default: begin
                        res.read_data = '0;
                    end
                endcase
            end
            ppi_pkg::OP_CPU_WRITE: begin
                case (req.port)
                    ppi_pkg::PORT_A: begin
                        if (!s.dir[ppi_pkg::DIR_A]) begin
                            s.latch_a = req.data;
                            if (m2) begin
                                s.flags[ppi_pkg::FLAG_WINT] = 1'b0;
                                if (s.flags[ppi_pkg::FLAG_DAK]) begin
                                    s.flags[ppi_pkg::FLAG_OBF] = 1'b0;
                                end
                            end
                            res.a_driven = 1'b1;
                        end
                    end
                    ppi_pkg::PORT_B: begin
                        if (!s.dir[ppi_pkg::DIR_B]) begin
                            s.latch_b    = req.data;
                            res.b_driven = 1'b1;
                        end
                    end
                    ppi_pkg::PORT_C: begin
                        if (s.ga_mode == ppi_pkg::GA_MODE_0) begin
                            if (s.gb_mode) begin
                                v = {v[7:4], s.latch_c[3:0]};
                            end
                        end else begin
                            s.latch_c[2:0] = v[2:0];
                            if (s.gb_mode) begin
                                v = s.latch_c;
                            end
                        end
                        if (!s.dir[ppi_pkg::DIR_CLO] && !s.gb_mode) begin
                            if (s.ga_mode == ppi_pkg::GA_MODE_0) begin
                                s.latch_c[3:0] = v[3:0];
                            end else begin
                                s.latch_c[2:0] = v[2:0];
                            end
                            res.c_low_driven = 1'b1;
                        end
                        if (!s.dir[ppi_pkg::DIR_CHI] && (s.ga_mode == ppi_pkg::GA_MODE_0)) begin
                            s.latch_c[7:3]    = v[7:3];
                            res.c_high_driven = 1'b1;
                        end
                    end
                    default: begin
                        if (req.data[7]) begin
                            s.ga_mode = req.data[6] ? ppi_pkg::GA_MODE_2 :
                                        (req.data[5] ? ppi_pkg::GA_MODE_1 : ppi_pkg::GA_MODE_0);
                            s.gb_mode = req.data[2];
                            s.dir     = {req.data[4], req.data[3], req.data[1], req.data[0]};
                            s.latch_a = '0;
                            s.latch_b = '0;
                            s.latch_c = req.data[6] ? ppi_pkg::C_MODE2_RESET : '0;
                        end else begin
                            if (m2) begin
                                if (bit_idx == ppi_pkg::CBIT_RIE) begin
                                    s.ien[ppi_pkg::EN_RIE] = req.data[0];
                                    to_c = 1'b0;
                                end else if (bit_idx == ppi_pkg::CBIT_WIE) begin
                                    s.ien[ppi_pkg::EN_WIE] = req.data[0];
                                    to_c = 1'b0;
                                end else if (bit_idx == ppi_pkg::CBIT_INTR
                                          || bit_idx == ppi_pkg::CBIT_IBF
                                          || bit_idx == ppi_pkg::CBIT_OBF) begin
                                    to_c = 1'b0;
                                end
                            end
                            if (to_c) begin
                                s.latch_c[bit_idx] = req.data[0];
                            end
                            res.bit_command_seen = 1'b1;
                        end
                    end
                endcase
            end
            ppi_pkg::OP_STROBE: begin
                if (m2) begin
                    s.strobe_buffer = req.data;
                    if (s.flags[ppi_pkg::FLAG_STB]) begin
                        s.flags[ppi_pkg::FLAG_IBF] = 1'b1;
                    end
                    if (s.flags[ppi_pkg::FLAG_IBF]) begin
                        s.flags[ppi_pkg::FLAG_RINT] = 1'b1;
                    end
                    s.flags[ppi_pkg::FLAG_STB] = 1'b1;
                end
            end
            default: begin
                if (m2) begin
                    if (s.flags[ppi_pkg::FLAG_DAK]) begin
                        s.flags[ppi_pkg::FLAG_OBF] = 1'b1;
                    end
                    if (s.flags[ppi_pkg::FLAG_OBF]) begin
                        s.flags[ppi_pkg::FLAG_WINT] = 1'b1;
                    end
                    s.flags[ppi_pkg::FLAG_DAK] = 1'b1;
                end
                res.read_data = s.latch_a;
            end
        endcase

        res.port_a_value = s.latch_a;
        res.port_b_value = s.latch_b;
        res.port_c_value = s.latch_c;
        res.input_full   = (s.ga_mode == ppi_pkg::GA_MODE_2) & s.flags[ppi_pkg::FLAG_IBF];
        res.output_full  = (s.ga_mode == ppi_pkg::GA_MODE_2) & s.flags[ppi_pkg::FLAG_OBF];
        state_out        = s;
    end

endmodule

/* src/ppi_checker.sv */
// Port checker for the parallel peripheral interface and its bind statement.
module ppi_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input ppi_pkg::req_t s_req,
    input logic          m_valid,
    input logic          m_ready,
    input ppi_pkg::res_t m_res
);

    // The result channel is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result stays and keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("stalled result changed");

    // A bit command drives no port and returns no data.
    a_bit_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.bit_command_seen |->
            !m_res.a_driven && !m_res.b_driven && !m_res.c_low_driven
            && !m_res.c_high_driven && (m_res.read_data == 8'd0))
        else $error("bit command result inconsistent");

    // A write of port A or B touches no other port and returns no data.
    a_ab_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_res.a_driven || m_res.b_driven) |->
            !(m_res.a_driven && m_res.b_driven) && !m_res.c_low_driven
            && !m_res.c_high_driven && (m_res.read_data == 8'd0))
        else $error("port write result inconsistent");

    // The request channel is not stalled while the result channel is empty.
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(!m_valid) && $past(aresetn) |-> s_ready)
        else $error("request stalled with empty result channel");

endmodule

bind parallel_peripheral_interface ppi_checker u_ppi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_req   (s_req),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_res   (m_res)
);
